/* rtl/cclp_pkg.sv */
// ----------------------------------------------------------------------------
// Console command line parser package
// Shared types, codes and keyword tables for the parser front, queue and back.
// ----------------------------------------------------------------------------
package cclp_pkg;

  // Classification that the front attaches to every accepted byte.
  typedef enum logic [1:0] {
    ITEM_SKIP,
    ITEM_WS,
    ITEM_CHAR,
    ITEM_OVERFLOW
  } item_kind_t;

  // One classified byte travelling from the front to the back.
  typedef struct packed {
    logic [7:0] ch;
    item_kind_t kind;
    logic       last;
  } queue_entry_t;

  // Parser phases of the back.
  typedef enum logic [2:0] {
    PH_LEAD,
    PH_BODY,
    PH_GOTO_AFTER,
    PH_GOTO_SEP,
    PH_GOTO_DIGITS,
    PH_TOO_LONG
  } parse_phase_t;

  localparam int QUEUE_DEPTH = 2;

  // Keyword slots: status, help, nine commands, then goto.
  localparam int KW_COUNT    = 12;
  localparam int KW_STATUS   = 0;
  localparam int KW_HELP     = 1;
  localparam int KW_CMD_BASE = 2;
  localparam int KW_GOTO     = 11;

  // Result status codes.
  localparam logic [2:0] ST_EMPTY       = 3'd0;
  localparam logic [2:0] ST_STATUS      = 3'd1;
  localparam logic [2:0] ST_HELP        = 3'd2;
  localparam logic [2:0] ST_COMMAND     = 3'd3;
  localparam logic [2:0] ST_TOO_LONG    = 3'd4;
  localparam logic [2:0] ST_BAD_SLIDE   = 3'd5;
  localparam logic [2:0] ST_UNSUPPORTED = 3'd6;

  localparam logic [3:0] CMD_NONE = 4'd0;
  localparam logic [3:0] CMD_GOTO = 4'd9;

  localparam logic [13:0] SLIDE_SAT = 14'd10000;
  localparam logic [13:0] SLIDE_MAX = 14'd9999;

  localparam logic [7:0] CHAR_SPACE = 8'h20;

  // C-locale whitespace: tab through carriage return, and space.
  function automatic logic is_ws(input logic [7:0] c);
    return (c == CHAR_SPACE) || (c >= 8'h09 && c <= 8'h0d);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  // Folds A-Z to lower case; everything else passes unchanged.
  function automatic logic [7:0] fold_lower(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5a) ? (c | 8'h20) : c;
  endfunction

  function automatic logic [3:0] kw_len(input logic [3:0] k);
    logic [3:0] len;
    case (k)
      4'd0:    len = 4'd6;
      4'd3:    len = 4'd8;
      4'd4:    len = 4'd5;
      4'd5:    len = 4'd13;
      4'd7:    len = 4'd5;
      4'd8:    len = 4'd5;
      4'd9:    len = 4'd5;
      default: len = 4'd4;
    endcase
    return len;
  endfunction

  // Keyword text, right-justified: the first character sits highest.
  function automatic logic [103:0] kw_text(input logic [3:0] k);
    logic [103:0] text;
    case (k)
      4'd0:    text = 104'("status");
      4'd1:    text = 104'("help");
      4'd2:    text = 104'("next");
      4'd3:    text = 104'("previous");
      4'd4:    text = 104'("start");
      4'd5:    text = 104'("start-current");
      4'd6:    text = 104'("stop");
      4'd7:    text = 104'("black");
      4'd8:    text = 104'("white");
      4'd9:    text = 104'("first");
      4'd10:   text = 104'("last");
      default: text = 104'("goto");
    endcase
    return text;
  endfunction

  // Character of keyword k at position pos, or zero past its end.
  function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [3:0] pos);
    logic [3:0]   len;
    logic [3:0]   idx;
    logic [103:0] text;
    len  = kw_len(k);
    text = kw_text(k);
    idx  = len - pos - 4'd1;
    if (pos >= len) begin
      return 8'h00;
    end
    return text[{idx, 3'b000} +: 8];
  endfunction

endpackage

/* rtl/cclp_front.sv */
// ----------------------------------------------------------------------------
// Console command line parser front
// Counts text bytes, tracks the end of text and the length limit, and tags
// each accepted byte with its class and folded value for the back.
// ----------------------------------------------------------------------------
module cclp_front #(
  parameter int MAX_LINE_BYTES = 128
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic [7:0]            ch,
  input  logic                  last,
  output cclp_pkg::queue_entry_t entry
);
  import cclp_pkg::*;

  localparam int COUNT_W = $clog2(MAX_LINE_BYTES + 1);
  localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(MAX_LINE_BYTES);

  logic [COUNT_W-1:0] byte_count;
  logic               text_ended;
  logic               overflowed;

  // Classify the incoming byte against the line state.
  always_comb begin
    entry.ch   = fold_lower(ch);
    entry.last = last;
    if (text_ended || overflowed || ch == 8'h00) begin
      entry.kind = ITEM_SKIP;
    end else if (byte_count >= COUNT_LIMIT) begin
      entry.kind = ITEM_OVERFLOW;
    end else if (is_ws(ch)) begin
      entry.kind = ITEM_WS;
    end else begin
      entry.kind = ITEM_CHAR;
    end
  end

  // Line state; cleared at the end of every line.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      text_ended <= 1'b0;
      overflowed <= 1'b0;
    end else if (accept) begin
      if (last) begin
        byte_count <= '0;
        text_ended <= 1'b0;
        overflowed <= 1'b0;
      end else begin
        if (!text_ended && !overflowed && ch == 8'h00) begin
          text_ended <= 1'b1;
        end
        if (entry.kind == ITEM_OVERFLOW) begin
          overflowed <= 1'b1;
        end
        if (entry.kind == ITEM_WS || entry.kind == ITEM_CHAR) begin
          byte_count <= byte_count + COUNT_W'(1);
        end
      end
    end
  end

endmodule

/* rtl/cclp_queue.sv */
// ----------------------------------------------------------------------------
// Console command line parser queue
// Short first-in first-out buffer of classified bytes between front and back.
// ----------------------------------------------------------------------------
module cclp_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  cclp_pkg::queue_entry_t push_data,
  output logic                   full,
  input  logic                   pop,
  output logic                   pop_valid,
  output cclp_pkg::queue_entry_t pop_data
);
  import cclp_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  queue_entry_t       mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full      = (count == CNT_W'(QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_data  = mem[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

/* rtl/cclp_back.sv */
// ----------------------------------------------------------------------------
// Console command line parser back
// Runs the keyword and goto operand matcher on classified bytes and registers
// one result per line in the output stage.
// ----------------------------------------------------------------------------
module cclp_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   entry_valid,
  input  cclp_pkg::queue_entry_t entry,
  output logic                   pop,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [23:0]            m_tdata
);
  import cclp_pkg::*;

  typedef struct packed {
    parse_phase_t          phase;
    logic [KW_COUNT-1:0]   candidates;
    logic [3:0]            match_pos;
    logic                  pending;
    logic                  goto_err;
    logic [13:0]           acc;
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '{
    phase:      PH_LEAD,
    candidates: '1,
    match_pos:  '0,
    pending:    1'b0,
    goto_err:   1'b0,
    acc:        '0
  };

  parse_state_t cur;
  parse_state_t cur_next;
  logic [2:0]   res_status;
  logic [3:0]   res_command;
  logic [13:0]  res_slide;

  // Feeds one trimmed, folded character to the matcher.
  function automatic parse_state_t feed(input parse_state_t s, input logic [7:0] c);
    parse_state_t r;
    logic [16:0]  prod;
    r = s;
    prod = ({3'b000, s.acc} << 3) + ({3'b000, s.acc} << 1) + {13'b0, c[3:0]};
    case (s.phase)
      PH_BODY: begin
        for (int k = 0; k < KW_COUNT; k++) begin
          if (kw_char(4'(k), s.match_pos) != c) begin
            r.candidates[k] = 1'b0;
          end
        end
        if (s.match_pos != 4'hf) begin
          r.match_pos = s.match_pos + 4'd1;
        end
        if (r.match_pos == 4'd4 && r.candidates[KW_GOTO]) begin
          r.phase = PH_GOTO_AFTER;
        end
      end
      PH_GOTO_AFTER: begin
        if (is_ws(c)) begin
          r.phase = PH_GOTO_SEP;
        end else begin
          r.goto_err = 1'b1;
          r.phase    = PH_GOTO_DIGITS;
        end
      end
      default: begin
        if (!(s.phase == PH_GOTO_SEP && is_ws(c))) begin
          r.phase = PH_GOTO_DIGITS;
          if (is_digit(c)) begin
            r.acc = (prod > {3'b000, SLIDE_SAT}) ? SLIDE_SAT : prod[13:0];
          end else begin
            r.goto_err = 1'b1;
          end
        end
      end
    endcase
    return r;
  endfunction

  // Take an entry unless it ends a line while the output stage is still full.
  assign pop = entry_valid && (!entry.last || !m_tvalid || m_tready);

  // Next parser state.
  always_comb begin
    cur_next = cur;
    if (pop) begin
      unique case (entry.kind)
        ITEM_OVERFLOW: begin
          cur_next.phase = PH_TOO_LONG;
        end
        ITEM_WS: begin
          if (cur.phase != PH_LEAD && cur.phase != PH_TOO_LONG) begin
            cur_next.pending = 1'b1;
          end
        end
        ITEM_CHAR: begin
          if (cur.phase != PH_TOO_LONG) begin
            if (cur.phase == PH_LEAD) begin
              cur_next.phase = PH_BODY;
            end
            if (cur_next.pending) begin
              cur_next         = feed(cur_next, CHAR_SPACE);
              cur_next.pending = 1'b0;
            end
            cur_next = feed(cur_next, entry.ch);
          end
        end
        ITEM_SKIP: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Line result from the state after the final byte.
  always_comb begin
    res_status  = ST_UNSUPPORTED;
    res_command = CMD_NONE;
    res_slide   = '0;
    unique case (cur_next.phase)
      PH_TOO_LONG: res_status = ST_TOO_LONG;
      PH_LEAD:     res_status = ST_EMPTY;
      PH_BODY: begin
        for (int k = KW_GOTO - 1; k >= 0; k--) begin
          if (cur_next.candidates[k] && cur_next.match_pos == kw_len(4'(k))) begin
            if (k == KW_STATUS) begin
              res_status  = ST_STATUS;
              res_command = CMD_NONE;
            end else if (k == KW_HELP) begin
              res_status  = ST_HELP;
              res_command = CMD_NONE;
            end else begin
              res_status  = ST_COMMAND;
              res_command = 4'(k - KW_CMD_BASE);
            end
          end
        end
      end
      default: begin
        if (cur_next.phase == PH_GOTO_DIGITS && !cur_next.goto_err &&
            cur_next.acc != '0 && cur_next.acc <= SLIDE_MAX) begin
          res_status  = ST_COMMAND;
          res_command = CMD_GOTO;
          res_slide   = cur_next.acc;
        end else begin
          res_status = ST_BAD_SLIDE;
        end
      end
    endcase
  end

  // Parser state; it returns to reset after every line.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= STATE_RESET;
    end else if (pop && entry.last) begin
      cur <= STATE_RESET;
    end else begin
      cur <= cur_next;
    end
  end

  // Output stage: holds one result until the downstream transaction completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop && entry.last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && entry.last) begin
      m_tdata <= {3'b000, res_slide, res_command, res_status};
    end
  end

endmodule

/* rtl/console_command_line_parser.sv */
// ----------------------------------------------------------------------------
// Console command line parser
// Accepts one console byte per transaction and returns one parse result when
// the byte marked last has been taken.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle, sustained, with results taken as offered.
// Path: the last byte of a line is written into the two-entry queue and leaves it
//   once the output stage is free; the result then loads the output register.
// Reset: synchronous, active high; clears the line state, the queue and the
//   output stage, and the block is ready to accept bytes when reset is released.
module console_command_line_parser #(
  parameter int MAX_LINE_BYTES = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] ch
  input  logic        s_tlast,   // last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // [2:0] status, [6:3] command, [20:7] slide
);
  import cclp_pkg::*;

  queue_entry_t front_entry;
  queue_entry_t back_entry;
  logic         queue_full;
  logic         queue_valid;
  logic         queue_pop;
  logic         in_accept;

  assign s_tready  = !queue_full;
  assign in_accept = s_tvalid && s_tready;

  // Classify incoming bytes.
  cclp_front #(
    .MAX_LINE_BYTES(MAX_LINE_BYTES)
  ) u_front (
    .clk   (clk),
    .rst   (rst),
    .accept(in_accept),
    .ch    (s_tdata),
    .last  (s_tlast),
    .entry (front_entry)
  );

  // Decouple the front from the matcher.
  cclp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (in_accept),
    .push_data(front_entry),
    .full     (queue_full),
    .pop      (queue_pop),
    .pop_valid(queue_valid),
    .pop_data (back_entry)
  );

  // Match keywords and produce results.
  cclp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .entry_valid(queue_valid),
    .entry      (back_entry),
    .pop        (queue_pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// Console command line parser testbench
// Sends console lines byte by byte and checks each parse result. A short
// table of directed lines covers keywords, goto operands, whitespace, zero
// bytes and overlong lines. Random lines follow, mostly well formed with some
// broken lines and noise. An in-bench parser predicts all but the typed results.
// ----------------------------------------------------------------------------
module tb_top;
  import cclp_pkg::*;

  typedef logic [7:0] octet_t;

  // One parse result as it travels on the master side.
  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  command;
    logic [13:0] slide;
  } parse_result_t;

  // One directed line; fill bytes follow the text, and a zero byte may be
  // inserted at a given index.
  typedef struct {
    string         text;
    int            fill_n;
    octet_t        fill_c;
    int            zero_at;
    bit            typed;
    parse_result_t want;
  } line_row_t;

  localparam int LINE_LIMIT    = 128;
  localparam int RANDOM_ITEMS  = 180;
  localparam int LONG_HOLD     = 80;
  localparam int DRAIN_CYCLES  = 20;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // [7:0] ch
  logic        s_tlast;   // last
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;   // [2:0] status, [6:3] command, [20:7] slide

  parse_result_t expected_results[$];
  line_row_t     line_table[$];

  int  mismatch_count  = 0;
  int  results_checked = 0;
  int  goto_results    = 0;
  int  items_sent      = 0;
  int  lines_sent      = 0;
  bit  idle_on         = 1'b1;
  bit  hold_req        = 1'b0;
  bit  hold_done       = 1'b0;

  // Line state of the in-bench parser.
  int           ln_bytes;
  bit           ln_ended;
  logic [11:0]  ln_cand;
  int           ln_pos;
  parse_phase_t ln_phase;
  bit           ln_space;
  bit           ln_bad;
  int           ln_acc;

  parse_result_t got;
  parse_result_t want;

  console_command_line_parser u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  // Keyword slots in the order of the candidate bits.
  function automatic string keyword_text(input int k);
    case (k)
      0:       return "status";
      1:       return "help";
      2:       return "next";
      3:       return "previous";
      4:       return "start";
      5:       return "start-current";
      6:       return "stop";
      7:       return "black";
      8:       return "white";
      9:       return "first";
      10:      return "last";
      default: return "goto";
    endcase
  endfunction

  function automatic bit is_blank(input octet_t c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic void clear_line();
    ln_bytes = 0;
    ln_ended = 1'b0;
    ln_cand  = '1;
    ln_pos   = 0;
    ln_phase = PH_LEAD;
    ln_space = 1'b0;
    ln_bad   = 1'b0;
    ln_acc   = 0;
  endfunction

  // Advances keyword matching or the goto operand by one trimmed character.
  function automatic void match_char(input octet_t c);
    string w;
    int    v;
    if (ln_phase == PH_BODY) begin
      for (int k = 0; k < KW_COUNT; k++) begin
        if (ln_cand[k]) begin
          w = keyword_text(k);
          if (ln_pos >= w.len() || octet_t'(w[ln_pos]) != c) ln_cand[k] = 1'b0;
        end
      end
      if (ln_pos < 255) ln_pos++;
      if (ln_pos == 4 && ln_cand[KW_GOTO]) ln_phase = PH_GOTO_AFTER;
      return;
    end
    if (ln_phase == PH_GOTO_AFTER) begin
      if (is_blank(c)) begin
        ln_phase = PH_GOTO_SEP;
      end else begin
        ln_bad   = 1'b1;
        ln_phase = PH_GOTO_DIGITS;
      end
      return;
    end
    if (ln_phase == PH_GOTO_SEP && is_blank(c)) return;
    ln_phase = PH_GOTO_DIGITS;
    if (c >= 8'h30 && c <= 8'h39) begin
      v      = ln_acc * 10 + int'(c - 8'h30);
      ln_acc = (v > int'(SLIDE_SAT)) ? int'(SLIDE_SAT) : v;
    end else begin
      ln_bad = 1'b1;
    end
  endfunction

  // Predicts one accepted byte; returns 1 when the byte closes the line.
  function automatic bit predict_parse(input octet_t b, input bit eol,
                                       output parse_result_t res);
    bit found;
    string w;
    found = 1'b0;
    res   = '{status: ST_UNSUPPORTED, command: CMD_NONE, slide: '0};
    if (!ln_ended) begin
      if (b == 8'h00) begin
        ln_ended = 1'b1;
      end else if (ln_phase != PH_TOO_LONG) begin
        if (ln_bytes >= LINE_LIMIT) begin
          ln_phase = PH_TOO_LONG;
        end else begin
          ln_bytes++;
          if (is_blank(b)) begin
            if (ln_phase != PH_LEAD) ln_space = 1'b1;
          end else begin
            if (ln_phase == PH_LEAD) ln_phase = PH_BODY;
            if (ln_space) begin
              match_char(8'd32);
              ln_space = 1'b0;
            end
            match_char((b >= 8'h41 && b <= 8'h5a) ? b + 8'd32 : b);
          end
        end
      end
    end
    if (!eol) return 1'b0;

    // Classify the finished line.
    if (ln_phase == PH_TOO_LONG) begin
      res.status = ST_TOO_LONG;
    end else if (ln_phase == PH_LEAD) begin
      res.status = ST_EMPTY;
    end else if (ln_phase == PH_BODY) begin
      for (int k = 0; k < KW_GOTO; k++) begin
        w = keyword_text(k);
        if (!found && ln_cand[k] && ln_pos == w.len()) begin
          found = 1'b1;
          if (k == KW_STATUS) begin
            res.status = ST_STATUS;
          end else if (k == KW_HELP) begin
            res.status = ST_HELP;
          end else begin
            res.status  = ST_COMMAND;
            res.command = 4'(k - KW_CMD_BASE);
          end
        end
      end
    end else if (ln_phase == PH_GOTO_DIGITS && !ln_bad && ln_acc >= 1 &&
                 ln_acc <= int'(SLIDE_MAX)) begin
      res.status  = ST_COMMAND;
      res.command = CMD_GOTO;
      res.slide   = 14'(ln_acc);
    end else begin
      res.status = ST_BAD_SLIDE;
    end
    clear_line();
    return 1'b1;
  endfunction

  function automatic void add_row(input string text, input int fill_n = 0,
                                  input octet_t fill_c = 8'h20,
                                  input int zero_at = -1, input bit typed = 1'b0,
                                  input logic [2:0] st = ST_EMPTY,
                                  input logic [13:0] slide = '0);
    line_row_t r;
    r.text    = text;
    r.fill_n  = fill_n;
    r.fill_c  = fill_c;
    r.zero_at = zero_at;
    r.typed   = typed;
    r.want    = '{status: st, command: CMD_NONE, slide: slide};
    line_table.push_back(r);
  endfunction

  function automatic void append_text(ref octet_t q[$], input string s,
                                      input bit mix_case);
    octet_t c;
    for (int i = 0; i < s.len(); i++) begin
      c = octet_t'(s[i]);
      if (mix_case && c >= 8'h61 && c <= 8'h7a && $urandom_range(0, 1) == 1) c -= 8'd32;
      q.push_back(c);
    end
  endfunction

  function automatic void append_blanks(ref octet_t q[$], input int lo, input int hi);
    int     n;
    octet_t c;
    n = $urandom_range(lo, hi);
    for (int i = 0; i < n; i++) begin
      c = octet_t'($urandom_range(8, 13));
      q.push_back((c == 8'd8) ? 8'd32 : c);
    end
  endfunction

  // Random line: mostly keywords and goto commands, then broken ones, noise and overlong lines.
  function automatic void random_line(ref octet_t q[$]);
    int    kind;
    int    n;
    int    i;
    string digits;
    q.delete();
    kind = $urandom_range(0, 99);
    if (kind < 45) begin
      append_blanks(q, 0, 2);
      append_text(q, keyword_text($urandom_range(0, 10)), 1'b1);
      append_blanks(q, 0, 2);
    end else if (kind < 75) begin
      append_blanks(q, 0, 1);
      append_text(q, "goto", 1'b1);
      if ($urandom_range(0, 9) != 0) append_blanks(q, 1, 3);
      n = $urandom_range(0, 9);
      if (n < 6)      digits = $sformatf("%0d", $urandom_range(1, 9999));
      else if (n < 7) digits = "0";
      else if (n < 9) digits = $sformatf("%0d", $urandom_range(10000, 999999));
      else            digits = $sformatf("%0d%0d", $urandom_range(1, 99999),
                                         $urandom_range(0, 99999));
      if ($urandom_range(0, 4) == 0) digits = {"00", digits};
      if ($urandom_range(0, 19) == 0) digits = "";
      append_text(q, digits, 1'b0);
      if ($urandom_range(0, 9) == 0) q.push_back(octet_t'($urandom_range(1, 255)));
      append_blanks(q, 0, 2);
    end else if (kind < 88) begin
      // A keyword with one character replaced, a blank inside, or cut short.
      append_text(q, keyword_text($urandom_range(0, 11)), 1'b1);
      i = $urandom_range(0, q.size() - 1);
      n = $urandom_range(0, 2);
      if (n == 0)      q[i] = octet_t'($urandom_range(0, 255));
      else if (n == 1) q.insert(i, 8'd32);
      else             void'(q.pop_back());
    end else if (kind < 98) begin
      n = $urandom_range(1, 12);
      for (int j = 0; j < n; j++) q.push_back(octet_t'($urandom_range(0, 255)));
    end else begin
      n = $urandom_range(LINE_LIMIT - 8, LINE_LIMIT + 12);
      for (int j = 0; j < n; j++) q.push_back(octet_t'($urandom_range(32, 126)));
    end
    if ($urandom_range(0, 19) == 0) q.insert($urandom_range(0, q.size()), 8'h00);
    if (q.size() == 0) q.push_back(8'h00);
  endfunction

  // Sends one line; the valid stays high into the next line when no gap falls.
  task automatic send_line(input octet_t q[$], input bit typed,
                           input parse_result_t typed_res);
    parse_result_t res;
    for (int i = 0; i < q.size(); i++) begin
      if (idle_on && $urandom_range(0, 4) == 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      s_tdata  <= q[i];
      s_tlast  <= (i == q.size() - 1);
      s_tvalid <= 1'b1;
      @(posedge clk);
      while (!s_tready) @(posedge clk);
      items_sent++;
      if (predict_parse(q[i], i == q.size() - 1, res))
        expected_results.push_back(typed ? typed_res : res);
    end
    lines_sent++;
  endtask

  // Lowers the valid and waits until every expected result has arrived.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  // Result checker.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got = '{status: m_tdata[2:0], command: m_tdata[6:3], slide: m_tdata[20:7]};
      if (expected_results.size() == 0) begin
        $error("result with no line pending: status %0d command %0d slide %0d",
               got.status, got.command, got.slide);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (got.status == ST_COMMAND && got.command == CMD_GOTO) goto_results++;
        if (got.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, got.status);
          mismatch_count++;
        end
        if (got.command !== want.command) begin
          $error("command: expected %0d, actual %0d", want.command, got.command);
          mismatch_count++;
        end
        if (got.slide !== want.slide) begin
          $error("slide: expected %0d, actual %0d", want.slide, got.slide);
          mismatch_count++;
        end
      end
    end
  end

  // Result side: random stalls, one long hold-off on request.
  initial begin
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  // Run limit.
  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Stimulus.
  initial begin
    octet_t        q[$];
    parse_result_t none;
    int            base;
    bit            drained;

    none    = '{status: ST_EMPTY, command: CMD_NONE, slide: '0};
    drained = 1'b0;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tlast  <= 1'b0;
    clear_line();

    // Directed lines: typed results where they are obvious, else predicted.
    add_row("", 0, 8'h20, 0, 1'b1, ST_EMPTY);
    add_row(" \t\n\v\f\r ", 0, 8'h20, -1, 1'b1, ST_EMPTY);
    add_row("status", 0, 8'h20, -1, 1'b1, ST_STATUS);
    add_row("  HELP \r", 0, 8'h20, -1, 1'b1, ST_HELP);
    add_row("help", 0, 8'h20, 4, 1'b1, ST_HELP);
    add_row("next");
    add_row("Previous");
    add_row("start");
    add_row("START-Current");
    add_row("\tstop");
    add_row("black ");
    add_row("wHiTe");
    add_row("first");
    add_row("last");
    add_row("goto 1");
    add_row("goto 9999");
    add_row(" GOTO \t 0042  ");
    add_row("goto 0", 0, 8'h20, -1, 1'b1, ST_BAD_SLIDE);
    add_row("goto 10000", 0, 8'h20, -1, 1'b1, ST_BAD_SLIDE);
    add_row("goto 99999999999", 0, 8'h20, -1, 1'b1, ST_BAD_SLIDE);
    add_row("goto", 0, 8'h20, -1, 1'b1, ST_BAD_SLIDE);
    add_row("goto12", 0, 8'h20, -1, 1'b1, ST_BAD_SLIDE);
    add_row("goto 12a", 0, 8'h20, -1, 1'b1, ST_BAD_SLIDE);
    add_row("start current", 0, 8'h20, -1, 1'b1, ST_UNSUPPORTED);
    add_row("stat", 2, 8'hd3, -1, 1'b1, ST_UNSUPPORTED);
    add_row("", LINE_LIMIT + 1, 8'h61, -1, 1'b1, ST_TOO_LONG);
    add_row("next", LINE_LIMIT - 4, 8'h20);
    add_row("stop", LINE_LIMIT, 8'h78, 4);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (line_table[r]) begin
      q.delete();
      append_text(q, line_table[r].text, 1'b0);
      repeat (line_table[r].fill_n) q.push_back(line_table[r].fill_c);
      if (line_table[r].zero_at >= 0) q.insert(line_table[r].zero_at, 8'h00);
      send_line(q, line_table[r].typed, line_table[r].want);
    end

    // Random lines, with one long result hold-off and one full drain.
    base = items_sent;
    while (items_sent - base < RANDOM_ITEMS) begin
      if (items_sent - base >= 40) hold_req = 1'b1;
      if (!drained && items_sent - base >= 90) begin
        drain_results();
        drained = 1'b1;
      end
      if (items_sent - base >= 140) idle_on = 1'b0;
      random_line(q);
      send_line(q, 1'b0, none);
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d lines in %0d bytes and checked %0d results, %0d of them goto.",
             lines_sent, items_sent, results_checked, goto_results);
    $display("Output held off once for %0d cycles; input paused once for a full drain.",
             LONG_HOLD);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/cclp_pkg.sv
rtl/cclp_front.sv
rtl/cclp_queue.sv
rtl/cclp_back.sv
rtl/console_command_line_parser.sv
dv/tb_top.sv
